@@ hdl/twor_pkg.sv @@
// Shared types, codes and constants of the triangle winding orientation block.
// Used by the controller, the datapath and the top level.
package twor_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 1024;
  localparam logic [63:0] MIN_AREA_RESET   = 64'd184467;
  localparam logic [15:0] UNIT_ONE         = 16'd16384;
  localparam logic [63:0] SQRT_FIRST_BIT   = 64'h4000_0000_0000_0000;

  localparam logic [4:0] VSQ_LAST   = 5'd3;
  localparam logic [4:0] SQRT_LAST  = 5'd31;
  localparam logic [4:0] DIV_LAST   = 5'd17;
  localparam logic [4:0] READ_LAST  = 5'd3;
  localparam logic [4:0] CROSS_LAST = 5'd6;
  localparam logic [4:0] AREA_LAST  = 5'd3;
  localparam logic [4:0] DOT_LAST   = 5'd6;
  localparam logic [1:0] LANE_LAST  = 2'd2;

  typedef enum logic [1:0] {
    MODE_VERTEX   = 2'd0,
    MODE_TRIANGLE = 2'd1,
    MODE_NEW_MESH = 2'd2,
    MODE_RESERVED = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_OVERFLOW   = 2'd1,
    ST_DEGENERATE = 2'd2,
    ST_UNWRITTEN  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_VSQ, S_VSQRT, S_VDIV, S_VWRITE,
    S_TREAD, S_TCROSS, S_TAREA, S_TDECIDE, S_TDOT, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SET_OVF, OP_CLEAR, OP_VSQ, OP_VSQRT, OP_VDIV,
    OP_VWRITE, OP_TREAD, OP_TCROSS, OP_TAREA, OP_TDOT, OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    RES_OK, RES_OVF, RES_UNW, RES_DEGEN, RES_VERTEX, RES_TRI
  } res_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] cnt;
    logic [1:0] lane;
    res_t       res;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  ovf;
    logic  full;
    logic  bad_corner;
    logic  degenerate;
  } stat_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [15:0] raw_normal_x;
    logic signed [15:0] raw_normal_y;
    logic signed [15:0] raw_normal_z;
    logic [9:0]         corner_a;
    logic [9:0]         corner_b;
    logic [9:0]         corner_c;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [9:0]         vertex_index;
    logic signed [15:0] unit_x;
    logic signed [15:0] unit_y;
    logic signed [15:0] unit_z;
    logic [9:0]         emit_a;
    logic [9:0]         emit_b;
    logic [9:0]         emit_c;
    logic               flipped;
  } out_item_t;

endpackage

@@ hdl/twor_if.sv @@
// Valid/ready channel interfaces for input items and result items.
// Stand-alone; no package dependency.
interface twor_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [23:0] pos_z;
  logic signed [15:0] raw_normal_x;
  logic signed [15:0] raw_normal_y;
  logic signed [15:0] raw_normal_z;
  logic [9:0]         corner_a;
  logic [9:0]         corner_b;
  logic [9:0]         corner_c;

  modport source (output valid, mode, pos_x, pos_y, pos_z, raw_normal_x, raw_normal_y,
                  raw_normal_z, corner_a, corner_b, corner_c, input ready);
  modport sink (input valid, mode, pos_x, pos_y, pos_z, raw_normal_x, raw_normal_y,
                raw_normal_z, corner_a, corner_b, corner_c, output ready);
endinterface

interface twor_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [9:0]         vertex_index;
  logic signed [15:0] unit_x;
  logic signed [15:0] unit_y;
  logic signed [15:0] unit_z;
  logic [9:0]         emit_a;
  logic [9:0]         emit_b;
  logic [9:0]         emit_c;
  logic               flipped;

  modport source (output valid, status, vertex_index, unit_x, unit_y, unit_z, emit_a,
                  emit_b, emit_c, flipped, input ready);
  modport sink (input valid, status, vertex_index, unit_x, unit_y, unit_z, emit_a,
                emit_b, emit_c, flipped, output ready);
endinterface

@@ hdl/twor_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module twor_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ hdl/twor_ctrl.sv @@
// Controller state machine: sequences vertex and triangle work on the datapath.
// Depends on twor_pkg.
module twor_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  twor_pkg::stat_t stat,
  output twor_pkg::cmd_t  cmd
);

  twor_pkg::state_t state_r, state_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [1:0]       lane_r, lane_nxt;
  twor_pkg::res_t   res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= twor_pkg::S_IDLE;
      cnt_r       <= '0;
      lane_r      <= '0;
      res_r       <= twor_pkg::RES_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      lane_r      <= lane_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    lane_nxt      = lane_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.op        = twor_pkg::OP_NONE;
    cmd.cnt       = cnt_r;
    cmd.lane      = lane_r;
    cmd.res       = res_r;
    unique case (state_r)
      twor_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = twor_pkg::OP_LOAD;
          state_nxt = twor_pkg::S_DISPATCH;
        end
      end
      twor_pkg::S_DISPATCH: begin
        cnt_nxt  = '0;
        lane_nxt = '0;
        unique case (stat.mode)
          twor_pkg::MODE_VERTEX: begin
            if (stat.ovf || stat.full) begin
              cmd.op    = twor_pkg::OP_SET_OVF;
              res_nxt   = twor_pkg::RES_OVF;
              state_nxt = twor_pkg::S_DONE;
            end else begin
              state_nxt = twor_pkg::S_VSQ;
            end
          end
          twor_pkg::MODE_TRIANGLE: begin
            if (stat.ovf) begin
              res_nxt   = twor_pkg::RES_OVF;
              state_nxt = twor_pkg::S_DONE;
            end else if (stat.bad_corner) begin
              res_nxt   = twor_pkg::RES_UNW;
              state_nxt = twor_pkg::S_DONE;
            end else begin
              state_nxt = twor_pkg::S_TREAD;
            end
          end
          twor_pkg::MODE_NEW_MESH: begin
            cmd.op    = twor_pkg::OP_CLEAR;
            res_nxt   = twor_pkg::RES_OK;
            state_nxt = twor_pkg::S_DONE;
          end
          twor_pkg::MODE_RESERVED: begin
            res_nxt   = twor_pkg::RES_OK;
            state_nxt = twor_pkg::S_DONE;
          end
        endcase
      end
      twor_pkg::S_VSQ: begin
        cmd.op = twor_pkg::OP_VSQ;
        if (cnt_r == twor_pkg::VSQ_LAST) begin
          cnt_nxt   = '0;
          state_nxt = twor_pkg::S_VSQRT;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      twor_pkg::S_VSQRT: begin
        cmd.op = twor_pkg::OP_VSQRT;
        if (cnt_r == twor_pkg::SQRT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = twor_pkg::S_VDIV;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      twor_pkg::S_VDIV: begin
        cmd.op = twor_pkg::OP_VDIV;
        if (cnt_r == twor_pkg::DIV_LAST) begin
          cnt_nxt = '0;
          if (lane_r == twor_pkg::LANE_LAST) begin
            state_nxt = twor_pkg::S_VWRITE;
          end else begin
            lane_nxt = lane_r + 2'd1;
          end
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      twor_pkg::S_VWRITE: begin
        cmd.op    = twor_pkg::OP_VWRITE;
        res_nxt   = twor_pkg::RES_VERTEX;
        state_nxt = twor_pkg::S_DONE;
      end
      twor_pkg::S_TREAD: begin
        cmd.op = twor_pkg::OP_TREAD;
        if (cnt_r == twor_pkg::READ_LAST) begin
          cnt_nxt   = '0;
          state_nxt = twor_pkg::S_TCROSS;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      twor_pkg::S_TCROSS: begin
        cmd.op = twor_pkg::OP_TCROSS;
        if (cnt_r == twor_pkg::CROSS_LAST) begin
          cnt_nxt   = '0;
          state_nxt = twor_pkg::S_TAREA;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      twor_pkg::S_TAREA: begin
        cmd.op = twor_pkg::OP_TAREA;
        if (cnt_r == twor_pkg::AREA_LAST) begin
          cnt_nxt   = '0;
          state_nxt = twor_pkg::S_TDECIDE;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      twor_pkg::S_TDECIDE: begin
        if (stat.degenerate) begin
          res_nxt   = twor_pkg::RES_DEGEN;
          state_nxt = twor_pkg::S_DONE;
        end else begin
          state_nxt = twor_pkg::S_TDOT;
        end
      end
      twor_pkg::S_TDOT: begin
        cmd.op = twor_pkg::OP_TDOT;
        if (cnt_r == twor_pkg::DOT_LAST) begin
          cnt_nxt   = '0;
          res_nxt   = twor_pkg::RES_TRI;
          state_nxt = twor_pkg::S_DONE;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      twor_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = twor_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = twor_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = twor_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

@@ hdl/twor_dp.sv @@
// Datapath: vertex store, shared multiplier, square root and divider steps,
// cross, area and facing accumulators and the result register.
// Depends on twor_pkg and twor_ram.
module twor_dp #(
  parameter int unsigned MAX_VERTICES = twor_pkg::MAX_VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  twor_pkg::cmd_t      cmd,
  input  twor_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic [63:0]         cfg_wdata,
  output twor_pkg::stat_t     stat,
  output twor_pkg::out_item_t out_item
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned IW = (CW > 10) ? CW : 10;

  twor_pkg::in_item_t  item_r;
  twor_pkg::out_item_t out_r, out_nxt;
  logic [CW-1:0]       count_r;
  logic                ovf_r;
  logic [63:0]         min_area_r;

  logic signed [33:0]  mul_a, mul_b;
  logic signed [67:0]  prod_r;

  logic [31:0]         s_r;
  logic [63:0]         v_r, r_r, bit_r;
  logic [31:0]         rem_r;
  logic [15:0]         q_r;
  logic signed [15:0]  unit_r [3];
  logic [9:0]          vidx_r;

  logic signed [23:0]  pa_r [3];
  logic signed [24:0]  e1_r [3];
  logic signed [24:0]  e2_r [3];
  logic signed [17:0]  ns_r [3];
  logic signed [50:0]  cr_r [3];
  logic [63:0]         area_r;
  logic                big_r;
  logic signed [71:0]  acc_r;

  logic                ram_we;
  logic [AW-1:0]       ram_raddr;
  logic [119:0]        ram_wdata, ram_rdata;

  logic signed [15:0]  nrm [3];
  logic signed [23:0]  rd_pos [3];
  logic signed [15:0]  rd_nrm [3];
  logic [4:0]          prev_cnt;
  logic [1:0]          prev_lane;
  logic [1:0]          area_lane;
  logic [1:0]          dot_lane;
  logic [50:0]         cr_mag;
  logic [31:0]         s_sum;
  logic [63:0]         sqrt_t;
  logic signed [15:0]  div_n;
  logic [15:0]         div_mag;
  logic [43:0]         numer;
  logic [31:0]         div_sh;
  logic                div_ge;
  logic [15:0]         q_cap;
  logic [64:0]         area_sum;
  logic                flip;

  assign nrm[0] = item_r.raw_normal_x;
  assign nrm[1] = item_r.raw_normal_y;
  assign nrm[2] = item_r.raw_normal_z;

  assign rd_pos[0] = ram_rdata[119:96];
  assign rd_pos[1] = ram_rdata[95:72];
  assign rd_pos[2] = ram_rdata[71:48];
  assign rd_nrm[0] = ram_rdata[47:32];
  assign rd_nrm[1] = ram_rdata[31:16];
  assign rd_nrm[2] = ram_rdata[15:0];

  assign prev_cnt  = cmd.cnt - 5'd1;
  assign prev_lane = prev_cnt[2:1];
  assign area_lane = cmd.cnt[1:0];
  assign dot_lane  = cmd.cnt[2:1];

  always_comb begin
    cr_mag = '0;
    if (area_lane != 2'd3) begin
      cr_mag = cr_r[area_lane][50] ? 51'(-cr_r[area_lane]) : 51'(cr_r[area_lane]);
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      twor_pkg::OP_VSQ: begin
        if (area_lane != 2'd3) begin
          mul_a = 34'(nrm[area_lane]);
          mul_b = 34'(nrm[area_lane]);
        end
      end
      twor_pkg::OP_TCROSS: begin
        unique case (cmd.cnt)
          5'd0: begin mul_a = 34'(e1_r[1]); mul_b = 34'(e2_r[2]); end
          5'd1: begin mul_a = 34'(e1_r[2]); mul_b = 34'(e2_r[1]); end
          5'd2: begin mul_a = 34'(e1_r[2]); mul_b = 34'(e2_r[0]); end
          5'd3: begin mul_a = 34'(e1_r[0]); mul_b = 34'(e2_r[2]); end
          5'd4: begin mul_a = 34'(e1_r[0]); mul_b = 34'(e2_r[1]); end
          5'd5: begin mul_a = 34'(e1_r[1]); mul_b = 34'(e2_r[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      twor_pkg::OP_TAREA: begin
        if (cr_mag[50:32] == '0) begin
          mul_a = {2'b00, cr_mag[31:0]};
          mul_b = {2'b00, cr_mag[31:0]};
        end
      end
      twor_pkg::OP_TDOT: begin
        if (dot_lane != 2'd3) begin
          mul_b = 34'(ns_r[dot_lane]);
          if (!cmd.cnt[0]) begin
            mul_a = {2'b00, cr_r[dot_lane][31:0]};
          end else begin
            mul_a = 34'($signed(cr_r[dot_lane][50:32]));
          end
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign s_sum    = s_r + prod_r[31:0];
  assign sqrt_t   = r_r + bit_r;
  assign div_n    = (cmd.lane != 2'd3) ? nrm[cmd.lane] : 16'sd0;
  assign div_mag  = div_n[15] ? 16'(-div_n) : 16'(div_n);
  assign numer    = {div_mag, 28'd0} + 44'(r_r[63:1]);
  assign div_sh   = {rem_r[30:0], q_r[15]};
  assign div_ge   = div_sh >= r_r[31:0];
  assign q_cap    = (q_r > twor_pkg::UNIT_ONE) ? twor_pkg::UNIT_ONE : q_r;
  assign area_sum = {1'b0, area_r} + {1'b0, prod_r[63:0]};
  assign flip     = acc_r < 0;

  always_comb begin
    ram_raddr = AW'(item_r.corner_a);
    unique case (cmd.cnt)
      5'd1:    ram_raddr = AW'(item_r.corner_b);
      5'd2:    ram_raddr = AW'(item_r.corner_c);
      default: ram_raddr = AW'(item_r.corner_a);
    endcase
  end

  assign ram_we    = cmd.op == twor_pkg::OP_VWRITE;
  assign ram_wdata = {item_r.pos_x, item_r.pos_y, item_r.pos_z,
                      unit_r[0], unit_r[1], unit_r[2]};

  twor_ram #(
    .WIDTH (120),
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(count_r)),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      ovf_r      <= 1'b0;
      min_area_r <= twor_pkg::MIN_AREA_RESET;
    end else begin
      if (cfg_we) begin
        min_area_r <= cfg_wdata;
      end
      unique case (cmd.op)
        twor_pkg::OP_SET_OVF: ovf_r <= 1'b1;
        twor_pkg::OP_CLEAR: begin
          count_r <= '0;
          ovf_r   <= 1'b0;
        end
        twor_pkg::OP_VWRITE: count_r <= count_r + CW'(1);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_nxt = '0;
    unique case (cmd.res)
      twor_pkg::RES_OVF:   out_nxt.status = twor_pkg::ST_OVERFLOW;
      twor_pkg::RES_UNW:   out_nxt.status = twor_pkg::ST_UNWRITTEN;
      twor_pkg::RES_DEGEN: out_nxt.status = twor_pkg::ST_DEGENERATE;
      twor_pkg::RES_VERTEX: begin
        out_nxt.status       = twor_pkg::ST_OK;
        out_nxt.vertex_index = vidx_r;
        out_nxt.unit_x       = unit_r[0];
        out_nxt.unit_y       = unit_r[1];
        out_nxt.unit_z       = unit_r[2];
      end
      twor_pkg::RES_TRI: begin
        out_nxt.status  = twor_pkg::ST_OK;
        out_nxt.emit_a  = item_r.corner_a;
        out_nxt.emit_b  = flip ? item_r.corner_c : item_r.corner_b;
        out_nxt.emit_c  = flip ? item_r.corner_b : item_r.corner_c;
        out_nxt.flipped = flip;
      end
      default: out_nxt.status = twor_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (cmd.op)
      twor_pkg::OP_LOAD: item_r <= in_item;
      twor_pkg::OP_VSQ: begin
        if (cmd.cnt == 5'd0) begin
          s_r <= '0;
        end else begin
          s_r <= s_sum;
        end
        if (cmd.cnt == twor_pkg::VSQ_LAST) begin
          v_r   <= {4'd0, s_sum, 28'd0};
          r_r   <= '0;
          bit_r <= twor_pkg::SQRT_FIRST_BIT;
        end
      end
      twor_pkg::OP_VSQRT: begin
        if (v_r >= sqrt_t) begin
          v_r <= v_r - sqrt_t;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      twor_pkg::OP_VDIV: begin
        if (cmd.cnt == 5'd0) begin
          rem_r <= 32'(numer[43:16]);
          q_r   <= numer[15:0];
        end else if (cmd.cnt == twor_pkg::DIV_LAST) begin
          if (cmd.lane != 2'd3) begin
            if (s_r == '0) begin
              unit_r[cmd.lane] <= '0;
            end else begin
              unit_r[cmd.lane] <= div_n[15] ? -$signed(q_cap) : $signed(q_cap);
            end
          end
        end else begin
          rem_r <= div_ge ? div_sh - r_r[31:0] : div_sh;
          q_r   <= {q_r[14:0], div_ge};
        end
      end
      twor_pkg::OP_VWRITE: vidx_r <= 10'(count_r);
      twor_pkg::OP_TREAD: begin
        unique case (cmd.cnt)
          5'd0: begin
            area_r <= '0;
            big_r  <= 1'b0;
            acc_r  <= '0;
            for (int k = 0; k < 3; k++) begin
              cr_r[k] <= '0;
            end
          end
          5'd1: begin
            for (int k = 0; k < 3; k++) begin
              pa_r[k] <= rd_pos[k];
              ns_r[k] <= 18'(rd_nrm[k]);
            end
          end
          5'd2: begin
            for (int k = 0; k < 3; k++) begin
              e1_r[k] <= 25'(rd_pos[k]) - 25'(pa_r[k]);
              ns_r[k] <= ns_r[k] + 18'(rd_nrm[k]);
            end
          end
          default: begin
            for (int k = 0; k < 3; k++) begin
              e2_r[k] <= 25'(rd_pos[k]) - 25'(pa_r[k]);
              ns_r[k] <= ns_r[k] + 18'(rd_nrm[k]);
            end
          end
        endcase
      end
      twor_pkg::OP_TCROSS: begin
        if (cmd.cnt != 5'd0 && prev_lane != 2'd3) begin
          if (!prev_cnt[0]) begin
            cr_r[prev_lane] <= cr_r[prev_lane] + prod_r[50:0];
          end else begin
            cr_r[prev_lane] <= cr_r[prev_lane] - prod_r[50:0];
          end
        end
      end
      twor_pkg::OP_TAREA: begin
        if (cmd.cnt != twor_pkg::AREA_LAST && cr_mag[50:32] != '0) begin
          big_r <= 1'b1;
        end
        if (cmd.cnt != 5'd0) begin
          area_r <= area_sum[64] ? '1 : area_sum[63:0];
        end
      end
      twor_pkg::OP_TDOT: begin
        if (cmd.cnt != 5'd0) begin
          if (!prev_cnt[0]) begin
            acc_r <= acc_r + 72'(prod_r);
          end else begin
            acc_r <= acc_r + (72'(prod_r) <<< 32);
          end
        end
      end
      twor_pkg::OP_OUT: out_r <= out_nxt;
      default: begin
      end
    endcase
  end

  assign stat.mode       = twor_pkg::mode_t'(item_r.mode);
  assign stat.ovf        = ovf_r;
  assign stat.full       = count_r == CW'(MAX_VERTICES);
  assign stat.bad_corner = (IW'(item_r.corner_a) >= IW'(count_r)) ||
                           (IW'(item_r.corner_b) >= IW'(count_r)) ||
                           (IW'(item_r.corner_c) >= IW'(count_r));
  assign stat.degenerate = !big_r && (area_r < min_area_r);
  assign out_item        = out_r;

endmodule

@@ hdl/triangle_winding_orient.sv @@
// Top level of the triangle winding orientation block: controller, datapath
// and channel wiring. Depends on twor_pkg, twor_if, twor_ctrl and twor_dp.
//
//   channel   direction  handshake       contents
//   in_ch     in         valid / ready   mode, position, raw normal, corners
//   out_ch    out        valid / ready   status, index, unit normal, triangle
//   cfg       in         cfg_we          min_area_squared (64 bit)
//
// A vertex item runs through accept, dispatch, the squaring steps, 32 square
// root steps and three divider passes on one shared divider, the store write
// and the result. A triangle item reads its three corners from the store one
// after another and works on the shared 34 by 34 multiplier; a degenerate one
// is dropped before the facing sum. Any other item goes from dispatch to the
// result. Reset clears the vertex count and the overflow flag and restores the
// default threshold; the store needs no clearing pass. A new item is taken
// while a result still waits; a stalled result holds the following one back.
module triangle_winding_orient #(
  parameter int unsigned MAX_VERTICES = twor_pkg::MAX_VERTICES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  twor_in_if.sink     in_ch,
  twor_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata
);

  twor_pkg::cmd_t      cmd;
  twor_pkg::stat_t     stat;
  twor_pkg::in_item_t  in_item;
  twor_pkg::out_item_t out_item;

  assign in_item.mode         = in_ch.mode;
  assign in_item.pos_x        = in_ch.pos_x;
  assign in_item.pos_y        = in_ch.pos_y;
  assign in_item.pos_z        = in_ch.pos_z;
  assign in_item.raw_normal_x = in_ch.raw_normal_x;
  assign in_item.raw_normal_y = in_ch.raw_normal_y;
  assign in_item.raw_normal_z = in_ch.raw_normal_z;
  assign in_item.corner_a     = in_ch.corner_a;
  assign in_item.corner_b     = in_ch.corner_b;
  assign in_item.corner_c     = in_ch.corner_c;

  twor_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  twor_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .out_item  (out_item)
  );

  assign out_ch.status       = out_item.status;
  assign out_ch.vertex_index = out_item.vertex_index;
  assign out_ch.unit_x       = out_item.unit_x;
  assign out_ch.unit_y       = out_item.unit_y;
  assign out_ch.unit_z       = out_item.unit_z;
  assign out_ch.emit_a       = out_item.emit_a;
  assign out_ch.emit_b       = out_item.emit_b;
  assign out_ch.emit_c       = out_item.emit_c;
  assign out_ch.flipped      = out_item.flipped;

endmodule
